>>> rtl/btlc_pkg.sv
// ----------------------------------------------------------------------------
// btlc_pkg
// Shared types and codes of the band-target linear classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package btlc_pkg;

  // input action codes
  localparam logic [1:0] ACT_PIXEL = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  // update kinds
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_RAISE = 2'd1;
  localparam logic [1:0] KIND_LOWER = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_LOW   = 2'd0;
  localparam logic [1:0] REG_HIGH  = 2'd1;
  localparam logic [1:0] REG_TRAIN = 2'd2;
  localparam logic [1:0] REG_COUNT = 2'd3;

  localparam logic [39:0] LOW_RESET   = 40'd559215000;
  localparam logic [39:0] HIGH_RESET  = 40'd585225000;
  localparam logic [10:0] COUNT_RESET = 11'd900;

  // gray = floor(sum / 3) = (sum * 683) >> 11, exact for sum < 2048
  localparam logic [9:0] DIV3_MUL   = 10'd683;
  localparam int         DIV3_SHIFT = 11;

  typedef struct packed {
    logic [1:0]         action;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [9:0]         weight_index;
    logic signed [23:0] weight_data;
  } in_t;

  typedef struct packed {
    logic signed [47:0] score;
    logic               in_band;
    logic [1:0]         update_kind;
    logic signed [23:0] weight_out;
  } out_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [7:0]         gray;
    logic [9:0]         idx;
    logic signed [23:0] data;
  } cmd_t;

  typedef struct packed {
    logic [39:0] low;
    logic [39:0] high;
    logic        train;
    logic [10:0] count;
  } cfg_t;

endpackage

`default_nettype wire

>>> rtl/btlc_front.sv
// ----------------------------------------------------------------------------
// btlc_front
// Decodes a request, forms the gray value and hands a command on.
// ----------------------------------------------------------------------------
`default_nettype none

module btlc_front (
  input  var btlc_pkg::in_t  req_i,
  input  wire                take_i,
  output var btlc_pkg::cmd_t cmd_o,
  output wire                push_o
);
  import btlc_pkg::*;

  logic [9:0]  sum;
  logic [19:0] prod;

  assign sum  = 10'(req_i.red) + 10'(req_i.green) + 10'(req_i.blue);
  assign prod = 20'(sum) * 20'(DIV3_MUL);

  always_comb begin
    cmd_o.op   = req_i.action;
    cmd_o.gray = prod[DIV3_SHIFT +: 8];
    cmd_o.idx  = req_i.weight_index;
    cmd_o.data = req_i.weight_data;
  end

  // unused action code is dropped here
  assign push_o = take_i && (req_i.action != ACT_NONE);

endmodule

`default_nettype wire

>>> rtl/btlc_fifo.sv
// ----------------------------------------------------------------------------
// btlc_fifo
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module btlc_fifo (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  input  var btlc_pkg::cmd_t cmd_i,
  input  wire                pop_i,
  output var btlc_pkg::cmd_t cmd_o,
  output wire                valid_o,
  output wire                full_o
);
  import btlc_pkg::*;

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= cmd_i;
  end

  assign cmd_o   = mem_q[rp_q];
  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);

endmodule

`default_nettype wire

>>> rtl/btlc_back.sv
// ----------------------------------------------------------------------------
// btlc_back
// Executes commands: weight and gray stores, score, training pass.
// ----------------------------------------------------------------------------
`default_nettype none

module btlc_back #(
  parameter int MAX_PIXELS = 1024
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  var btlc_pkg::cfg_t cfg_i,
  input  var btlc_pkg::cmd_t cmd_i,
  input  wire                cmd_valid_i,
  output wire                cmd_pop_o,
  output wire                res_valid_o,
  output var btlc_pkg::out_t res_o
);
  import btlc_pkg::*;

  localparam int AW = $clog2(MAX_PIXELS);
  localparam int CW = $clog2(MAX_PIXELS + 1);
  localparam int XW = (CW > 11) ? CW : 11;
  localparam int IW = ((AW > 10) ? AW : 10) + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PIX   = 3'd1;
  localparam logic [2:0] S_END   = 3'd2;
  localparam logic [2:0] S_TRAIN = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;
  localparam logic [2:0] S_READ  = 3'd5;

  logic signed [23:0] weight_mem [MAX_PIXELS];
  logic [7:0]         gray_mem   [MAX_PIXELS];

  logic [2:0]         state_q, state_d;
  logic signed [47:0] acc_q, acc_d;
  logic [AW-1:0]      pos_q, pos_d;
  logic [AW-1:0]      tr_q, tr_d;
  logic [7:0]         gray_q, gray_d;
  logic [1:0]         kind_q, kind_d;
  logic               rd_ok_q, rd_ok_d;
  logic               wb_v_q, wb_v_d;
  logic [AW-1:0]      wb_idx_q, wb_idx_d;
  logic               res_valid_q, res_valid_d;
  out_t               res_q, res_d;

  logic signed [23:0] w_rdata_q;
  logic [7:0]         g_rdata_q;
  logic [AW-1:0]      w_raddr, g_raddr, w_waddr;
  logic               w_we, g_we;
  logic signed [23:0] w_wdata;

  // active pixel count: zero acts as one, clamp to store depth
  logic [XW-1:0] cnt_x;
  logic [CW-1:0] cnt;
  always_comb begin
    cnt_x = XW'(cfg_i.count);
    if (cnt_x == '0) cnt_x = XW'(1);
    else if (cnt_x > XW'(MAX_PIXELS)) cnt_x = XW'(MAX_PIXELS);
    cnt = cnt_x[CW-1:0];
  end

  logic [IW-1:0] idx_x;
  logic          idx_ok;
  assign idx_x  = IW'(cmd_i.idx);
  assign idx_ok = idx_x < IW'(MAX_PIXELS);

  // pixel product and score compare
  logic signed [24:0] w_p1;
  logic signed [33:0] prod;
  logic [CW-1:0]      pos_nx, tr_nx;
  logic signed [48:0] sc_x, lo_x, hi_x;
  logic               below, above;
  assign w_p1   = 25'(w_rdata_q) + 25'sd1;
  assign prod   = $signed({1'b0, gray_q}) * w_p1;
  assign pos_nx = CW'(pos_q) + CW'(1);
  assign tr_nx  = CW'(tr_q) + CW'(1);
  assign sc_x   = 49'(acc_q);
  assign lo_x   = $signed({9'd0, cfg_i.low});
  assign hi_x   = $signed({9'd0, cfg_i.high});
  assign below  = sc_x < lo_x;
  assign above  = sc_x > hi_x;

  // training update with saturation
  logic signed [25:0] upd;
  logic signed [23:0] upd_sat;
  always_comb begin
    if (kind_q == KIND_RAISE) upd = 26'(w_rdata_q) + $signed({18'd0, g_rdata_q});
    else                      upd = 26'(w_rdata_q) - $signed({18'd0, g_rdata_q});
    if (upd > 26'sd8388607)       upd_sat = 24'sh7FFFFF;
    else if (upd < -26'sd8388608) upd_sat = 24'sh800000;
    else                          upd_sat = upd[23:0];
  end

  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i;

  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    pos_d       = pos_q;
    tr_d        = tr_q;
    gray_d      = gray_q;
    kind_d      = kind_q;
    rd_ok_d     = rd_ok_q;
    wb_v_d      = 1'b0;
    wb_idx_d    = wb_idx_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    w_raddr     = pos_q;
    g_raddr     = tr_q;
    w_we        = 1'b0;
    w_waddr     = idx_x[AW-1:0];
    w_wdata     = cmd_i.data;
    g_we        = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            ACT_PIXEL: begin
              g_we    = 1'b1;
              gray_d  = cmd_i.gray;
              state_d = S_PIX;
            end
            ACT_WRITE: w_we = idx_ok;
            ACT_READ: begin
              w_raddr = idx_x[AW-1:0];
              rd_ok_d = idx_ok;
              state_d = S_READ;
            end
            default: ;
          endcase
        end
      end
      S_PIX: begin
        acc_d = acc_q + 48'(prod);
        if (pos_nx >= cnt) begin
          pos_d   = '0;
          state_d = S_END;
        end else begin
          pos_d   = pos_nx[AW-1:0];
          state_d = S_IDLE;
        end
      end
      S_END: begin
        kind_d = KIND_NONE;
        if (cfg_i.train && below)      kind_d = KIND_RAISE;
        else if (cfg_i.train && above) kind_d = KIND_LOWER;
        res_valid_d       = 1'b1;
        res_d.score       = acc_q;
        res_d.in_band     = (sc_x > lo_x) && (sc_x < hi_x);
        res_d.update_kind = kind_d;
        res_d.weight_out  = '0;
        acc_d             = '0;
        tr_d              = '0;
        state_d           = (kind_d != KIND_NONE) ? S_TRAIN : S_IDLE;
      end
      S_TRAIN: begin
        w_raddr  = tr_q;
        wb_v_d   = 1'b1;
        wb_idx_d = tr_q;
        if (tr_nx >= cnt) state_d = S_FLUSH;
        else              tr_d    = tr_nx[AW-1:0];
      end
      S_FLUSH: state_d = S_IDLE;
      S_READ: begin
        res_valid_d       = 1'b1;
        res_d.score       = '0;
        res_d.in_band     = 1'b0;
        res_d.update_kind = KIND_NONE;
        res_d.weight_out  = rd_ok_q ? w_rdata_q : 24'sd0;
        state_d           = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    // training write-back, one entry behind the read
    if (wb_v_q) begin
      w_we    = 1'b1;
      w_waddr = wb_idx_q;
      w_wdata = upd_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      acc_q       <= '0;
      pos_q       <= '0;
      tr_q        <= '0;
      kind_q      <= KIND_NONE;
      rd_ok_q     <= 1'b0;
      wb_v_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      pos_q       <= pos_d;
      tr_q        <= tr_d;
      kind_q      <= kind_d;
      rd_ok_q     <= rd_ok_d;
      wb_v_q      <= wb_v_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gray_q   <= gray_d;
    wb_idx_q <= wb_idx_d;
    res_q    <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (w_we) weight_mem[w_waddr] <= w_wdata;
    w_rdata_q <= weight_mem[w_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (g_we) gray_mem[pos_q] <= cmd_i.gray;
    g_rdata_q <= gray_mem[g_raddr];
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

>>> rtl/band_target_linear_classifier_core.sv
// ----------------------------------------------------------------------------
// band_target_linear_classifier_core
// Gray-image linear classifier with band target and online weight training.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy rises
// only while the two-entry command queue is full. Results come out on
// res_o for one cycle with res_valid_o and cannot be held off. The back end
// runs one command at a time: a pixel is a weight read, then the
// multiply-accumulate; a read is a store read, then the output; a write
// is done while idle. The last pixel of an image adds the band compare,
// and with training on and the score off band a pass through the train
// and flush states walks the weight and gray stores (read one entry,
// write back the one before). New commands are popped only while idle, so
// none is started before the last one and its training pass are through.
// The weight store has no reset: read only entries that were written.
// Configuration goes through cfg_valid_i / cfg_index_i / cfg_data_i,
// always ready, and should change only when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module band_target_linear_classifier_core #(
  parameter int MAX_PIXELS = 1024
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start,
  output wire                busy,
  input  var btlc_pkg::in_t  req_i,
  input  wire                cfg_valid_i,
  output wire                cfg_ready_o,
  input  wire [1:0]          cfg_index_i,
  input  wire [39:0]         cfg_data_i,
  output wire                res_valid_o,
  output var btlc_pkg::out_t res_o
);
  import btlc_pkg::*;

  cfg_t cfg_q;
  cmd_t f_cmd, q_cmd;
  logic push, pop, q_valid, q_full;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low   <= LOW_RESET;
      cfg_q.high  <= HIGH_RESET;
      cfg_q.train <= 1'b0;
      cfg_q.count <= COUNT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_LOW:   cfg_q.low   <= cfg_data_i;
        REG_HIGH:  cfg_q.high  <= cfg_data_i;
        REG_TRAIN: cfg_q.train <= cfg_data_i[0];
        REG_COUNT: cfg_q.count <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end
  assign cfg_ready_o = 1'b1;

  assign busy = q_full;

  btlc_front u_front (
    .req_i  (req_i),
    .take_i (start && !q_full),
    .cmd_o  (f_cmd),
    .push_o (push)
  );

  btlc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (f_cmd),
    .pop_i   (pop),
    .cmd_o   (q_cmd),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  btlc_back #(.MAX_PIXELS(MAX_PIXELS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (q_cmd),
    .cmd_valid_i (q_valid),
    .cmd_pop_o   (pop),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire
